// ===== rtl/gai_pkg.sv =====
// ----------------------------------------------------------------------------
// gai_pkg
// Shared types and constants for the gyro attitude integrator.
// ----------------------------------------------------------------------------
package gai_pkg;

    // Number of gyro ticks between control updates.
    localparam int unsigned CONTROL_DIVIDE = 5;
    localparam int unsigned TICK_W         = 3;

    // 45 degree axis rotation: multiply by 181, then arithmetic shift by 8.
    localparam int unsigned ROT_SCALE = 181;
    localparam int unsigned ROT_SHIFT = 8;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned OFFSET_W = 12;
    localparam int unsigned ANGLE_W  = 32;
    // Offset-corrected sample, and a sum or negation of those.
    localparam int unsigned CORR_W   = 18;
    localparam int unsigned RATE_W   = CORR_W + 1;
    localparam int unsigned PROD_W   = RATE_W + ROT_SHIFT;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic signed [OFFSET_W-1:0] OFFSET_SHORT_RST  = -12'sd5;
    localparam logic signed [OFFSET_W-1:0] OFFSET_LONG_RST   = 12'sd15;
    localparam logic signed [OFFSET_W-1:0] OFFSET_NORMAL_RST = 12'sd0;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_LOAD = 2'd1,
        REQ_ZERO = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONTROL_ENABLE = 3'd0,
        CFG_PITCH_SETPOINT = 3'd1,
        CFG_ROLL_SETPOINT  = 3'd2,
        CFG_YAW_SETPOINT   = 3'd3,
        CFG_OFFSET_SHORT   = 3'd4,
        CFG_OFFSET_LONG    = 3'd5,
        CFG_OFFSET_NORMAL  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]                  req_type;
        logic signed [SAMPLE_W-1:0]  gyro_short;
        logic signed [SAMPLE_W-1:0]  gyro_long;
        logic signed [SAMPLE_W-1:0]  gyro_normal;
        logic                        in_air;
        logic signed [ANGLE_W-1:0]   ext_yaw;
        logic signed [ANGLE_W-1:0]   ext_roll;
        logic signed [ANGLE_W-1:0]   ext_pitch;
    } in_item_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0]   yaw_angle;
        logic signed [ANGLE_W-1:0]   roll_angle;
        logic signed [ANGLE_W-1:0]   pitch_angle;
        logic                        control_tick;
        logic                        force_off;
        logic                        ground_brake;
        logic signed [ANGLE_W-1:0]   pitch_target;
        logic signed [ANGLE_W-1:0]   roll_target;
        logic signed [ANGLE_W-1:0]   yaw_target;
    } out_item_t;

    // Item after rate computation, handed to the integrator stage.
    typedef struct packed {
        req_t                        req;
        logic signed [RATE_W-1:0]    yaw_rate;
        logic signed [RATE_W-1:0]    roll_rate;
        logic signed [RATE_W-1:0]    pitch_rate;
        logic                        in_air;
        logic signed [ANGLE_W-1:0]   ext_yaw;
        logic signed [ANGLE_W-1:0]   ext_roll;
        logic signed [ANGLE_W-1:0]   ext_pitch;
    } rate_item_t;

endpackage

// ===== rtl/gai_rate.sv =====
// ----------------------------------------------------------------------------
// gai_rate
// Input stage: removes gyro offsets, rotates board axes by 45 degrees and
// registers the resulting yaw, roll and pitch rates.
// ----------------------------------------------------------------------------
module gai_rate (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  gai_pkg::in_item_t                     s_data,
    input  logic signed [gai_pkg::OFFSET_W-1:0]   offset_short,
    input  logic signed [gai_pkg::OFFSET_W-1:0]   offset_long,
    input  logic signed [gai_pkg::OFFSET_W-1:0]   offset_normal,
    output logic                                  rate_valid,
    input  logic                                  rate_ready,
    output gai_pkg::rate_item_t                   rate_data
);

    localparam int unsigned CW = gai_pkg::CORR_W;
    localparam int unsigned RW = gai_pkg::RATE_W;
    localparam int unsigned PW = gai_pkg::PROD_W;
    localparam int unsigned SW = gai_pkg::SAMPLE_W;
    localparam int unsigned OW = gai_pkg::OFFSET_W;

    logic                 rate_vld_reg;
    gai_pkg::rate_item_t  rate_reg;
    gai_pkg::rate_item_t  rate_next;

    logic signed [CW-1:0] corr_short;
    logic signed [CW-1:0] corr_long;
    logic signed [CW-1:0] corr_normal;
    logic signed [RW-1:0] sum_nl;
    logic signed [RW-1:0] diff_ln;
    logic [PW-1:0]        prod_yaw;
    logic [PW-1:0]        prod_roll;
    logic                 accept;

    assign s_ready = !rate_vld_reg || rate_ready;
    assign accept  = s_valid && s_ready;

    assign corr_short  = {{(CW-SW){s_data.gyro_short[SW-1]}}, s_data.gyro_short}
                       - {{(CW-OW){offset_short[OW-1]}}, offset_short};
    assign corr_long   = {{(CW-SW){s_data.gyro_long[SW-1]}}, s_data.gyro_long}
                       - {{(CW-OW){offset_long[OW-1]}}, offset_long};
    assign corr_normal = {{(CW-SW){s_data.gyro_normal[SW-1]}}, s_data.gyro_normal}
                       - {{(CW-OW){offset_normal[OW-1]}}, offset_normal};

    assign sum_nl  = {corr_normal[CW-1], corr_normal} + {corr_long[CW-1], corr_long};
    assign diff_ln = {corr_long[CW-1], corr_long} - {corr_normal[CW-1], corr_normal};

    // The product fits well inside PW signed bits, so an unsigned multiply of
    // the sign-extended operand yields the correct two's complement result.
    assign prod_yaw  = {{(PW-RW){sum_nl[RW-1]}}, sum_nl} * PW'(gai_pkg::ROT_SCALE);
    assign prod_roll = {{(PW-RW){diff_ln[RW-1]}}, diff_ln} * PW'(gai_pkg::ROT_SCALE);

    always_comb begin
        rate_next            = '0;
        rate_next.req        = gai_pkg::req_t'(s_data.req_type);
        rate_next.yaw_rate   = prod_yaw[PW-1:gai_pkg::ROT_SHIFT];
        rate_next.roll_rate  = prod_roll[PW-1:gai_pkg::ROT_SHIFT];
        rate_next.pitch_rate = RW'(0) - {corr_short[CW-1], corr_short};
        rate_next.in_air     = s_data.in_air;
        rate_next.ext_yaw    = s_data.ext_yaw;
        rate_next.ext_roll   = s_data.ext_roll;
        rate_next.ext_pitch  = s_data.ext_pitch;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_vld_reg <= 1'b0;
        end else if (s_ready) begin
            rate_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rate_reg <= rate_next;
        end
    end

    assign rate_valid = rate_vld_reg;
    assign rate_data  = rate_reg;

endmodule

// ===== rtl/gai_integ.sv =====
// ----------------------------------------------------------------------------
// gai_integ
// Integrator stage: accumulates angle rates, counts ticks, issues control
// updates and registers the result beat.
// ----------------------------------------------------------------------------
module gai_integ (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 rate_valid,
    output logic                                 rate_ready,
    input  gai_pkg::rate_item_t                  rate_data,
    input  logic                                 control_enable,
    input  logic signed [gai_pkg::ANGLE_W-1:0]   pitch_setpoint,
    input  logic signed [gai_pkg::ANGLE_W-1:0]   roll_setpoint,
    input  logic signed [gai_pkg::ANGLE_W-1:0]   yaw_setpoint,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output gai_pkg::out_item_t                   m_data
);

    localparam int unsigned AW = gai_pkg::ANGLE_W;
    localparam int unsigned RW = gai_pkg::RATE_W;
    localparam int unsigned TW = gai_pkg::TICK_W;

    logic [AW-1:0] yaw_acc_reg,  yaw_acc_next;
    logic [AW-1:0] roll_acc_reg, roll_acc_next;
    logic [AW-1:0] pitch_acc_reg, pitch_acc_next;
    logic [TW-1:0] tick_count_reg, tick_count_next;
    logic [AW-1:0] held_pitch_reg, held_pitch_next;
    logic [AW-1:0] held_roll_reg,  held_roll_next;
    logic [AW-1:0] held_yaw_reg,   held_yaw_next;
    logic          brake_mode_reg, brake_mode_next;
    logic          m_vld_reg;
    gai_pkg::out_item_t m_data_reg, m_data_next;

    logic          advance;
    logic [TW-1:0] tick_inc;
    logic          ctick;
    logic          foff;

    assign rate_ready = !m_vld_reg || m_ready;
    assign advance    = rate_valid && rate_ready;
    assign tick_inc   = tick_count_reg + TW'(1);

    always_comb begin
        yaw_acc_next    = yaw_acc_reg;
        roll_acc_next   = roll_acc_reg;
        pitch_acc_next  = pitch_acc_reg;
        tick_count_next = tick_count_reg;
        held_pitch_next = held_pitch_reg;
        held_roll_next  = held_roll_reg;
        held_yaw_next   = held_yaw_reg;
        brake_mode_next = brake_mode_reg;
        ctick           = 1'b0;
        foff            = 1'b0;

        unique case (rate_data.req)
            gai_pkg::REQ_TICK: begin
                yaw_acc_next   = yaw_acc_reg
                               + {{(AW-RW){rate_data.yaw_rate[RW-1]}}, rate_data.yaw_rate};
                roll_acc_next  = roll_acc_reg
                               + {{(AW-RW){rate_data.roll_rate[RW-1]}}, rate_data.roll_rate};
                pitch_acc_next = pitch_acc_reg
                               + {{(AW-RW){rate_data.pitch_rate[RW-1]}},
                                  rate_data.pitch_rate};
                tick_count_next = tick_inc;
                if (tick_inc >= TW'(gai_pkg::CONTROL_DIVIDE)) begin
                    tick_count_next = '0;
                    ctick           = 1'b1;
                    if (!control_enable) begin
                        foff = 1'b1;
                    end else begin
                        if (rate_data.in_air) begin
                            brake_mode_next = 1'b0;
                            held_pitch_next = pitch_setpoint;
                        end else begin
                            brake_mode_next = 1'b1;
                        end
                        held_roll_next = roll_setpoint;
                        held_yaw_next  = yaw_setpoint;
                    end
                end
            end
            gai_pkg::REQ_LOAD: begin
                yaw_acc_next   = rate_data.ext_yaw;
                roll_acc_next  = rate_data.ext_roll;
                pitch_acc_next = rate_data.ext_pitch;
            end
            gai_pkg::REQ_ZERO: begin
                yaw_acc_next   = '0;
                roll_acc_next  = '0;
                pitch_acc_next = '0;
            end
            default: begin
            end
        endcase

        m_data_next.yaw_angle    = yaw_acc_next;
        m_data_next.roll_angle   = roll_acc_next;
        m_data_next.pitch_angle  = pitch_acc_next;
        m_data_next.control_tick = ctick;
        m_data_next.force_off    = foff;
        m_data_next.ground_brake = brake_mode_next;
        m_data_next.pitch_target = held_pitch_next;
        m_data_next.roll_target  = held_roll_next;
        m_data_next.yaw_target   = held_yaw_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yaw_acc_reg    <= '0;
            roll_acc_reg   <= '0;
            pitch_acc_reg  <= '0;
            tick_count_reg <= '0;
            held_pitch_reg <= '0;
            held_roll_reg  <= '0;
            held_yaw_reg   <= '0;
            brake_mode_reg <= 1'b0;
        end else if (advance) begin
            yaw_acc_reg    <= yaw_acc_next;
            roll_acc_reg   <= roll_acc_next;
            pitch_acc_reg  <= pitch_acc_next;
            tick_count_reg <= tick_count_next;
            held_pitch_reg <= held_pitch_next;
            held_roll_reg  <= held_roll_next;
            held_yaw_reg   <= held_yaw_next;
            brake_mode_reg <= brake_mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (rate_ready) begin
            m_vld_reg <= rate_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_vld_reg;
    assign m_data  = m_data_reg;

    // The tick counter wraps before it can reach the divide ratio.
    assert property (@(posedge aclk) disable iff (!aresetn)
        tick_count_reg < TW'(gai_pkg::CONTROL_DIVIDE))
        else $error("tick counter reached the divide ratio");

    // A control-update beat leaves the tick counter cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (!m_data_reg.control_tick || tick_count_reg == '0))
        else $error("control tick without counter restart");

    // Held targets move only when an item is integrated.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$past(advance)) |->
            ($stable(held_roll_reg) && $stable(held_yaw_reg) && $stable(held_pitch_reg)))
        else $error("held target changed without an item");

endmodule

// ===== rtl/gyro_attitude_integrator_top.sv =====
// ----------------------------------------------------------------------------
// gyro_attitude_integrator_top
// Gyro attitude integrator: configuration registers, rate stage and
// integrator stage.
// ----------------------------------------------------------------------------
// A result beat passes through the rate register and then the result register.
// Throughput: one item per cycle while the result side is ready; the input register and
// the result register form a two-stage pipeline with an accumulator feedback loop.
// Reset: synchronous, active low; angles, targets, tick counter and brake mode
// clear to zero, offsets return to -5, 15 and 0, control is disabled.
// Configuration writes are always accepted.
module gyro_attitude_integrator_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  gai_pkg::in_item_t                    s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output gai_pkg::out_item_t                   m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gai_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gai_pkg::ANGLE_W-1:0]          cfg_data
);

    localparam int unsigned AW = gai_pkg::ANGLE_W;
    localparam int unsigned OW = gai_pkg::OFFSET_W;

    logic                  control_enable_reg;
    logic signed [AW-1:0]  pitch_setpoint_reg;
    logic signed [AW-1:0]  roll_setpoint_reg;
    logic signed [AW-1:0]  yaw_setpoint_reg;
    logic signed [OW-1:0]  offset_short_reg;
    logic signed [OW-1:0]  offset_long_reg;
    logic signed [OW-1:0]  offset_normal_reg;

    logic                  rate_valid;
    logic                  rate_ready;
    gai_pkg::rate_item_t   rate_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            control_enable_reg <= 1'b0;
            pitch_setpoint_reg <= '0;
            roll_setpoint_reg  <= '0;
            yaw_setpoint_reg   <= '0;
            offset_short_reg   <= gai_pkg::OFFSET_SHORT_RST;
            offset_long_reg    <= gai_pkg::OFFSET_LONG_RST;
            offset_normal_reg  <= gai_pkg::OFFSET_NORMAL_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (gai_pkg::cfg_idx_t'(cfg_index))
                gai_pkg::CFG_CONTROL_ENABLE: control_enable_reg <= cfg_data[0];
                gai_pkg::CFG_PITCH_SETPOINT: pitch_setpoint_reg <= cfg_data;
                gai_pkg::CFG_ROLL_SETPOINT:  roll_setpoint_reg  <= cfg_data;
                gai_pkg::CFG_YAW_SETPOINT:   yaw_setpoint_reg   <= cfg_data;
                gai_pkg::CFG_OFFSET_SHORT:   offset_short_reg   <= cfg_data[OW-1:0];
                gai_pkg::CFG_OFFSET_LONG:    offset_long_reg    <= cfg_data[OW-1:0];
                gai_pkg::CFG_OFFSET_NORMAL:  offset_normal_reg  <= cfg_data[OW-1:0];
                default: begin
                end
            endcase
        end
    end

    gai_rate u_rate (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .offset_short  (offset_short_reg),
        .offset_long   (offset_long_reg),
        .offset_normal (offset_normal_reg),
        .rate_valid    (rate_valid),
        .rate_ready    (rate_ready),
        .rate_data     (rate_data)
    );

    gai_integ u_integ (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .rate_valid     (rate_valid),
        .rate_ready     (rate_ready),
        .rate_data      (rate_data),
        .control_enable (control_enable_reg),
        .pitch_setpoint (pitch_setpoint_reg),
        .roll_setpoint  (roll_setpoint_reg),
        .yaw_setpoint   (yaw_setpoint_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data)
    );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gyro attitude integrator. A scoreboard class
// keeps its own copy of the registers, angle accumulators, tick counter and
// held targets, predicts every result beat and compares it field by field.
// Directed beats cover sample and angle extremes, every request type and the
// control update paths; random phases follow under changing register values,
// with random idling on both channels and one long result-side hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gai_pkg::*;

    localparam int RATE_GAIN       = 181;
    localparam int RATE_SHIFT      = 8;
    localparam int MAX_REPORTS     = 10;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PHASE_COUNT     = 6;
    localparam int PHASE_BEATS     = 322;
    localparam int DRAIN_CYCLES    = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 3'd7;

    typedef enum int {
        SET_DIRECTED,
        SET_MAX,
        SET_MIN,
        SET_RANDOM
    } setting_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [ANGLE_W-1:0]   data;
    } cfg_beat_t;

    class attitude_scoreboard;
        logic                       ctl_enable;
        logic [ANGLE_W-1:0]         pitch_sp, roll_sp, yaw_sp;
        logic signed [OFFSET_W-1:0] off_short, off_long, off_normal;
        logic [ANGLE_W-1:0]         yaw_acc, roll_acc, pitch_acc;
        logic [TICK_W-1:0]          tick_count;
        logic [ANGLE_W-1:0]         pitch_tgt, roll_tgt, yaw_tgt;
        logic                       brake_mode;
        out_item_t                  expected_attitudes[$];
        int                         faults;

        function new();
            ctl_enable = 1'b0;
            pitch_sp   = '0;
            roll_sp    = '0;
            yaw_sp     = '0;
            off_short  = -12'sd5;
            off_long   = 12'sd15;
            off_normal = 12'sd0;
            yaw_acc    = '0;
            roll_acc   = '0;
            pitch_acc  = '0;
            tick_count = '0;
            pitch_tgt  = '0;
            roll_tgt   = '0;
            yaw_tgt    = '0;
            brake_mode = 1'b0;
            faults     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [ANGLE_W-1:0] data);
            case (index)
                CFG_CONTROL_ENABLE: ctl_enable = data[0];
                CFG_PITCH_SETPOINT: pitch_sp   = data;
                CFG_ROLL_SETPOINT:  roll_sp    = data;
                CFG_YAW_SETPOINT:   yaw_sp     = data;
                CFG_OFFSET_SHORT:   off_short  = data[OFFSET_W-1:0];
                CFG_OFFSET_LONG:    off_long   = data[OFFSET_W-1:0];
                CFG_OFFSET_NORMAL:  off_normal = data[OFFSET_W-1:0];
                default: ;
            endcase
        endfunction

        function out_item_t advance_attitude(in_item_t it);
            int        s_corr, l_corr, n_corr;
            int        yaw_rate, roll_rate;
            logic      ctick, foff;
            out_item_t r;
            ctick = 1'b0;
            foff  = 1'b0;
            case (req_t'(it.req_type))
                REQ_TICK: begin
                    s_corr = int'($signed(it.gyro_short)) - int'(off_short);
                    l_corr = int'($signed(it.gyro_long)) - int'(off_long);
                    n_corr = int'($signed(it.gyro_normal)) - int'(off_normal);
                    // The 45 degree rotation floors, so an arithmetic shift of a
                    // signed product matches it exactly.
                    yaw_rate  = ((n_corr + l_corr) * RATE_GAIN) >>> RATE_SHIFT;
                    roll_rate = ((l_corr - n_corr) * RATE_GAIN) >>> RATE_SHIFT;
                    yaw_acc   = yaw_acc + yaw_rate;
                    roll_acc  = roll_acc + roll_rate;
                    pitch_acc = pitch_acc - s_corr;
                    tick_count = tick_count + 1'b1;
                    if (tick_count >= CONTROL_DIVIDE) begin
                        tick_count = '0;
                        ctick = 1'b1;
                        if (!ctl_enable) begin
                            foff = 1'b1;
                        end else begin
                            if (it.in_air) begin
                                brake_mode = 1'b0;
                                pitch_tgt  = pitch_sp;
                            end else begin
                                brake_mode = 1'b1;
                            end
                            roll_tgt = roll_sp;
                            yaw_tgt  = yaw_sp;
                        end
                    end
                end
                REQ_LOAD: begin
                    yaw_acc   = it.ext_yaw;
                    roll_acc  = it.ext_roll;
                    pitch_acc = it.ext_pitch;
                end
                REQ_ZERO: begin
                    yaw_acc   = '0;
                    roll_acc  = '0;
                    pitch_acc = '0;
                end
                default: ;
            endcase
            r.yaw_angle    = yaw_acc;
            r.roll_angle   = roll_acc;
            r.pitch_angle  = pitch_acc;
            r.control_tick = ctick;
            r.force_off    = foff;
            r.ground_brake = brake_mode;
            r.pitch_target = pitch_tgt;
            r.roll_target  = roll_tgt;
            r.yaw_target   = yaw_tgt;
            return r;
        endfunction

        function void note_input(in_item_t it);
            expected_attitudes.push_back(advance_attitude(it));
        endfunction

        function string show(out_item_t o);
            return $sformatf("yaw %h roll %h pitch %h tick %b off %b brake %b tgt %h %h %h",
                o.yaw_angle, o.roll_angle, o.pitch_angle, o.control_tick, o.force_off,
                o.ground_brake, o.pitch_target, o.roll_target, o.yaw_target);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_attitudes.size() == 0) begin
                faults++;
                if (faults <= MAX_REPORTS)
                    $display("result beat with nothing expected: %s", show(got));
            end else begin
                want = expected_attitudes.pop_front();
                if (got.yaw_angle !== want.yaw_angle || got.roll_angle !== want.roll_angle ||
                    got.pitch_angle !== want.pitch_angle ||
                    got.control_tick !== want.control_tick ||
                    got.force_off !== want.force_off ||
                    got.ground_brake !== want.ground_brake ||
                    got.pitch_target !== want.pitch_target ||
                    got.roll_target !== want.roll_target ||
                    got.yaw_target !== want.yaw_target) begin
                    faults++;
                    if (faults <= MAX_REPORTS) begin
                        $display("attitude mismatch, expected %s", show(want));
                        $display("                   actual   %s", show(got));
                    end
                end
            end
        endfunction

        function int pending();
            return expected_attitudes.size();
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_item_t             s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_item_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ANGLE_W-1:0]   cfg_data = '0;

    bit                   idling = 1'b1;
    bit                   hold_pending = 1'b0;
    int                   quiet_cycles = 0;
    attitude_scoreboard   board;

    gyro_attitude_integrator_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [ANGLE_W-1:0] pick_angle();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [OFFSET_W-1:0] pick_offset();
        case ($urandom_range(0, 5))
            0: return 12'h7FF;
            1: return 12'h800;
            2: return 12'h000;
            default: return 12'($urandom());
        endcase
    endfunction

    function automatic in_item_t compose(input req_t req, input logic [SAMPLE_W-1:0] gs,
                                         input logic [SAMPLE_W-1:0] gl,
                                         input logic [SAMPLE_W-1:0] gn, input logic air,
                                         input logic [ANGLE_W-1:0] ey,
                                         input logic [ANGLE_W-1:0] er,
                                         input logic [ANGLE_W-1:0] ep);
        in_item_t it;
        it.req_type    = req;
        it.gyro_short  = gs;
        it.gyro_long   = gl;
        it.gyro_normal = gn;
        it.in_air      = air;
        it.ext_yaw     = ey;
        it.ext_roll    = er;
        it.ext_pitch   = ep;
        return it;
    endfunction

    function automatic in_item_t random_item();
        int   pick;
        req_t req;
        pick = $urandom_range(0, 99);
        if (pick < 82)
            req = REQ_TICK;
        else if (pick < 90)
            req = REQ_LOAD;
        else if (pick < 96)
            req = REQ_ZERO;
        else
            req = REQ_NONE;
        return compose(req, pick_sample(), pick_sample(), pick_sample(),
                       $urandom_range(0, 1) == 1, pick_angle(), pick_angle(), pick_angle());
    endfunction

    function automatic in_item_t tick(input logic [SAMPLE_W-1:0] gs,
                                      input logic [SAMPLE_W-1:0] gl,
                                      input logic [SAMPLE_W-1:0] gn, input logic air);
        return compose(REQ_TICK, gs, gl, gn, air, $urandom(), $urandom(), $urandom());
    endfunction

    function automatic in_item_t load(input logic [ANGLE_W-1:0] ey,
                                      input logic [ANGLE_W-1:0] er,
                                      input logic [ANGLE_W-1:0] ep);
        return compose(REQ_LOAD, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                       $urandom_range(0, 1) == 1, ey, er, ep);
    endfunction

    function automatic in_item_t other(input req_t req);
        return compose(req, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                       $urandom_range(0, 1) == 1, $urandom(), $urandom(), $urandom());
    endfunction

    // Valid stays high from one beat to the next unless a gap is inserted.
    task automatic send_item(input in_item_t it);
        if (idling && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_cfg_burst(input cfg_beat_t beats[$]);
        foreach (beats[i]) begin
            cfg_valid <= 1'b1;
            cfg_index <= beats[i].index;
            cfg_data  <= beats[i].data;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Upper data bits are random so that only the register's own width matters.
    task automatic program_settings(input setting_t mode);
        cfg_beat_t          beats[$];
        logic [ANGLE_W-1:0] word;
        for (int idx = 0; idx <= CFG_SPARE_INDEX; idx++) begin
            word = $urandom();
            case (mode)
                SET_MAX: begin
                    if (idx == CFG_CONTROL_ENABLE)
                        word[0] = 1'b1;
                    else if (idx >= CFG_OFFSET_SHORT)
                        word[OFFSET_W-1:0] = 12'h7FF;
                    else
                        word = 32'h7FFF_FFFF;
                end
                SET_MIN: begin
                    if (idx == CFG_CONTROL_ENABLE)
                        word[0] = 1'b0;
                    else if (idx >= CFG_OFFSET_SHORT)
                        word[OFFSET_W-1:0] = 12'h800;
                    else
                        word = 32'h8000_0000;
                end
                SET_DIRECTED: begin
                    case (idx)
                        CFG_CONTROL_ENABLE: word[0] = 1'b1;
                        CFG_PITCH_SETPOINT: word = 32'h7FFF_FFFF;
                        CFG_ROLL_SETPOINT:  word = 32'h8000_0000;
                        CFG_YAW_SETPOINT:   word = 32'hFFFF_FFFF;
                        CFG_OFFSET_SHORT:   word[OFFSET_W-1:0] = 12'h800;
                        CFG_OFFSET_LONG:    word[OFFSET_W-1:0] = 12'h7FF;
                        CFG_OFFSET_NORMAL:  word[OFFSET_W-1:0] = 12'h800;
                        default: ;
                    endcase
                end
                default: begin
                    if (idx == CFG_CONTROL_ENABLE)
                        word[0] = $urandom_range(0, 3) != 0;
                    else if (idx >= CFG_OFFSET_SHORT)
                        word[OFFSET_W-1:0] = pick_offset();
                    else
                        word = pick_angle();
                end
            endcase
            if (mode != SET_RANDOM || $urandom_range(0, 3) != 0)
                beats.push_back('{index: idx[CFG_IDX_W-1:0], data: word});
        end
        write_cfg_burst(beats);
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_pending = 1'b0;
                m_ready <= 1'b1;
            end else if (idling && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                board.write_reg(cfg_index, cfg_data);
            // The input beat is noted before the result beat of the same edge.
            if (s_valid && s_ready)
                board.note_input(s_data);
            if (m_valid && m_ready)
                board.check_result(m_data);
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    initial begin
        setting_t mode;
        board = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset register values: control disabled, so the fifth tick forces off.
        send_item(tick(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1));
        send_item(tick(16'h8000, 16'h8000, 16'h8000, 1'b0));
        send_item(tick(16'h7FFF, 16'h8000, 16'h7FFF, 1'b1));
        send_item(tick(16'h8000, 16'h7FFF, 16'h8000, 1'b0));
        send_item(tick(16'h0000, 16'h0000, 16'h0000, 1'b1));

        wait_for_drain();
        program_settings(SET_DIRECTED);

        // Yaw starts near the top so the next tick wraps it.
        send_item(load(32'h7FFF_FFF0, 32'h8000_0000, 32'h7FFF_FFFF));
        send_item(tick(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0));
        send_item(tick(16'h8000, 16'h7FFF, 16'h8000, 1'b1));
        send_item(tick(16'h1234, 16'hFEDC, 16'h0001, 1'b0));
        send_item(tick(16'hFFFF, 16'h0001, 16'hFFFF, 1'b1));
        // Fifth tick airborne: coast and the pitch target is loaded.
        send_item(tick(16'h0000, 16'h0000, 16'h0000, 1'b1));
        send_item(tick(16'h8000, 16'h8000, 16'h7FFF, 1'b1));
        send_item(other(REQ_NONE));
        send_item(tick(16'h7FFF, 16'h8000, 16'h8000, 1'b1));
        send_item(tick(16'h0100, 16'hFF00, 16'h00FF, 1'b0));
        send_item(tick(16'h0000, 16'h0001, 16'h0000, 1'b1));
        // Fifth tick on the ground: brake, pitch target held.
        send_item(tick(16'h5555, 16'hAAAA, 16'h5555, 1'b0));
        send_item(other(REQ_ZERO));
        send_item(load(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000));
        send_item(tick(16'h8000, 16'h8000, 16'h8000, 1'b0));
        send_item(load(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF));
        send_item(other(REQ_ZERO));

        for (int p = 0; p < PHASE_COUNT; p++) begin
            wait_for_drain();
            if (p == 0)
                mode = SET_MAX;
            else if (p == 3)
                mode = SET_MIN;
            else
                mode = SET_RANDOM;
            program_settings(mode);
            idling = (p != PHASE_COUNT - 1);
            if (p == 1)
                hold_pending = 1'b1;
            for (int k = 0; k < PHASE_BEATS; k++)
                send_item(random_item());
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.faults == 0 && board.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
